/* rtl/mvpf_pkg.sv */
// ----------------------------------------------------------------------------
// Motion-vector packet framer package
// Shared constants, the operation word passed from front end to back end,
// and the back-end phase type.
// ----------------------------------------------------------------------------
`default_nettype none

package mvpf_pkg;

  localparam int PACKET_WORDS = 256;
  localparam int CHUNK_WORDS  = 768;
  localparam int MAX_VECTORS  = 8192;

  localparam int IDX_W  = 14;  // array index and output position
  localparam int FILL_W = 10;  // words in the current chunk
  localparam int HALF_W = 16;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] HDR_WORD0 = 32'h0854_564E;
  localparam logic [31:0] HDR_WORD1 = 32'h4154_454D;
  localparam logic [31:0] HDR_WORD3 = 32'h1000_0801;
  localparam logic [31:0] MARK_WORD = 32'h0954_564E;

  localparam logic [15:0] SIZE_LIMIT_RESET = 16'd40000;

  // What the back end does with one queued entry
  typedef enum logic [1:0] {
    OP_WORD,    // one word
    OP_MARKED,  // one word, preceded by a marker on a packet boundary
    OP_PAIR,    // the given word, then the third header constant
    OP_REJECT   // rejection result
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] word;
    logic        last;   // final word of the frame
    logic        first;  // first word of the frame: restart the counters
  } op_t;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_t;

endpackage

`default_nettype wire

/* rtl/mvpf_front.sv */
// ----------------------------------------------------------------------------
// Motion-vector packet framer front end
// Accepts array words, tracks the array index, runs the frame checks and
// turns each word into at most one queued operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpf_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [31:0]  data_word,
  input  wire logic         frame_start,
  input  wire logic         q_full,
  output logic              push,
  output mvpf_pkg::op_t     push_op
);
  import mvpf_pkg::*;

  // array word positions
  localparam logic [IDX_W-1:0] W_SIZE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] W_TAG   = IDX_W'(1);
  localparam logic [IDX_W-1:0] W_SKIP0 = IDX_W'(2);
  localparam logic [IDX_W-1:0] W_HI0   = IDX_W'(3);
  localparam logic [IDX_W-1:0] W_LO0   = IDX_W'(4);
  localparam logic [IDX_W-1:0] W_SKIP1 = IDX_W'(5);
  localparam logic [IDX_W-1:0] W_SKIP2 = IDX_W'(6);
  localparam logic [IDX_W-1:0] W_HI1   = IDX_W'(7);
  localparam logic [IDX_W-1:0] W_LO1   = IDX_W'(8);
  localparam logic [IDX_W-1:0] W_HI2   = IDX_W'(9);
  localparam logic [IDX_W-1:0] W_LO2   = IDX_W'(10);
  localparam logic [IDX_W-1:0] W_HI3   = IDX_W'(11);
  localparam logic [IDX_W-1:0] W_LO3   = IDX_W'(12);
  localparam logic [IDX_W-1:0] W_COUNT = IDX_W'(13);
  localparam logic [IDX_W-1:0] W_VEC0  = IDX_W'(14);

  // positions after the last vector word
  localparam logic [IDX_W-1:0] T_HI_A = IDX_W'(0);
  localparam logic [IDX_W-1:0] T_LO_A = IDX_W'(1);
  localparam logic [IDX_W-1:0] T_HI_B = IDX_W'(2);

  logic [15:0]       meta_size_limit;
  logic [IDX_W-1:0]  word_index, word_index_next;
  logic [IDX_W-1:0]  vector_count, vector_count_next;
  logic [HALF_W-1:0] half_hold, half_hold_next;
  logic              frame_active, frame_active_next;

  logic              accept;
  logic              live;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  rel;
  logic [IDX_W-1:0]  tail;
  logic [31:0]       packed_word;

  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign live        = accept && (frame_start || frame_active);
  assign idx         = frame_start ? '0 : word_index;
  assign rel         = idx - W_VEC0;
  assign tail        = rel - vector_count;
  assign packed_word = {half_hold, data_word[HALF_W-1:0]};

  always_comb begin
    word_index_next   = word_index;
    vector_count_next = vector_count;
    half_hold_next    = half_hold;
    frame_active_next = frame_active;
    push              = 1'b0;
    push_op           = '{kind: OP_WORD, word: data_word, last: 1'b0, first: 1'b0};

    if (live) begin
      word_index_next = idx + IDX_W'(1);
      if (frame_start) begin
        frame_active_next = 1'b1;
        vector_count_next = '0;
        half_hold_next    = '0;
      end

      unique case (idx)
        W_SIZE: begin
          push = 1'b1;
          if (data_word[15:0] >= meta_size_limit && data_word[19:16] == 4'd0) begin
            push_op.kind      = OP_REJECT;
            frame_active_next = 1'b0;
          end else begin
            push_op.word  = HDR_WORD0;
            push_op.first = 1'b1;
          end
        end
        W_TAG: begin
          push         = 1'b1;
          push_op.word = HDR_WORD1;
        end
        W_SKIP0, W_SKIP1, W_SKIP2: begin
        end
        W_HI0, W_HI1, W_HI2, W_HI3: begin
          half_hold_next = data_word[HALF_W-1:0];
        end
        W_LO0: begin
          push         = 1'b1;
          push_op.kind = OP_PAIR;
          push_op.word = packed_word;
        end
        W_LO1, W_LO2, W_LO3: begin
          push         = 1'b1;
          push_op.word = packed_word;
        end
        W_COUNT: begin
          if (data_word > 32'(MAX_VECTORS)) begin
            push              = 1'b1;
            push_op.kind      = OP_REJECT;
            frame_active_next = 1'b0;
          end else begin
            vector_count_next = data_word[IDX_W-1:0];
          end
        end
        default: begin
          if (rel < vector_count) begin
            push         = 1'b1;
            push_op.kind = OP_MARKED;
          end else if (tail == T_HI_A || tail == T_HI_B) begin
            half_hold_next = data_word[HALF_W-1:0];
          end else if (tail == T_LO_A) begin
            push         = 1'b1;
            push_op.kind = OP_MARKED;
            push_op.word = packed_word;
          end else begin
            push              = 1'b1;
            push_op.word      = packed_word;
            push_op.last      = 1'b1;
            frame_active_next = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_size_limit <= SIZE_LIMIT_RESET;
      word_index      <= '0;
      vector_count    <= '0;
      half_hold       <= '0;
      frame_active    <= 1'b0;
    end else begin
      if (cfg_write) begin
        meta_size_limit <= cfg_data;
      end
      word_index   <= word_index_next;
      vector_count <= vector_count_next;
      half_hold    <= half_hold_next;
      frame_active <= frame_active_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/mvpf_queue.sv */
// ----------------------------------------------------------------------------
// Motion-vector packet framer operation queue
// Small first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mvpf_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output mvpf_pkg::op_t      head_op
);
  import mvpf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/mvpf_back.sv */
// ----------------------------------------------------------------------------
// Motion-vector packet framer back end
// Turns queued operations into output words, inserts packet markers,
// counts link chunks and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire mvpf_pkg::op_t head_op,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        tx_word,
  output logic               chunk_last,
  output logic               frame_last,
  output logic               rejected
);
  import mvpf_pkg::*;

  phase_t            phase, phase_next;
  logic [IDX_W-1:0]  out_position;
  logic [FILL_W-1:0] chunk_fill;

  logic              can_load;
  logic              fire;
  logic [IDX_W-1:0]  base_pos;
  logic [FILL_W-1:0] base_fill;
  logic [FILL_W:0]   fill;
  logic              mark_due;
  logic              cl;
  logic [31:0]       emit_word;
  logic              emit_last;
  logic              emit_reject;

  assign can_load  = !out_valid || out_ready;
  assign fire      = head_valid && can_load;
  assign base_pos  = head_op.first ? '0 : out_position;
  assign base_fill = head_op.first ? '0 : chunk_fill;
  assign fill      = {1'b0, base_fill} + (FILL_W + 1)'(1);
  assign mark_due  = (IDX_W'(base_pos % IDX_W'(PACKET_WORDS)) == '0);
  assign cl        = emit_last || (fill >= (FILL_W + 1)'(CHUNK_WORDS));

  // phase sequencing for two-word operations
  always_comb begin
    phase_next = phase;
    if (fire) begin
      unique case (phase)
        PH_FIRST: begin
          if (head_op.kind == OP_PAIR || (head_op.kind == OP_MARKED && mark_due)) begin
            phase_next = PH_SECOND;
          end
        end
        PH_SECOND: phase_next = PH_FIRST;
      endcase
    end
  end

  // word selection and queue pop
  always_comb begin
    emit_word   = head_op.word;
    emit_last   = head_op.last;
    emit_reject = 1'b0;
    pop         = 1'b0;
    unique case (phase)
      PH_FIRST: begin
        unique case (head_op.kind)
          OP_WORD: pop = fire;
          OP_MARKED: begin
            if (mark_due) begin
              emit_word = MARK_WORD;
              emit_last = 1'b0;
            end else begin
              pop = fire;
            end
          end
          OP_PAIR: emit_last = 1'b0;
          OP_REJECT: begin
            emit_reject = 1'b1;
            pop         = fire;
          end
        endcase
      end
      PH_SECOND: begin
        pop = fire;
        if (head_op.kind == OP_PAIR) begin
          emit_word = HDR_WORD3;
          emit_last = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx_word    <= emit_reject ? 32'd0 : emit_word;
      chunk_last <= !emit_reject && cl;
      frame_last <= emit_reject || emit_last;
      rejected   <= emit_reject;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      out_position <= '0;
      chunk_fill   <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase <= phase_next;
      if (fire && !emit_reject) begin
        out_position <= base_pos + IDX_W'(1);
        chunk_fill   <= cl ? '0 : fill[FILL_W-1:0];
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/motion_vector_packet_framer.sv */
// ----------------------------------------------------------------------------
// Motion-vector packet framer
// Frames a metadata array into header, vector and trailer words for a
// display link, with packet markers and link chunk marks.
// ----------------------------------------------------------------------------
// Feed the metadata array one word per cycle on the input channel, with
// frame_start high on array word 0. Word 0 and word 13 are checked; a frame
// that fails is answered, after any header words already sent, by a word
// with rejected and frame_last high (tx_word zero), and its remaining words
// are swallowed up to the next frame_start. A good frame leaves as a
// seven-word header, the vector words, and two packed trailer words; a
// marker word is slipped in ahead of any vector or first trailer word that
// would start a 256-word packet, and chunk_last flags every 768th word as
// well as the frame's final word. Throughput: the input takes one word per
// cycle while the four-entry operation queue has room. Words that produce
// nothing never reach the back end. The back end sends one word per cycle
// while out_ready is high, so an input word that yields two output words
// (header word 4, or a word that gets a marker) holds it for both; the
// queue soaks up these bursts and the input stalls only once it fills. An
// accepted word is first written into the queue and then loaded from it
// into the output register, where out_valid rises.
// meta_size_limit is written through cfg_write/cfg_data and resets to
// 40000; write it only while the block is idle. frame_start in mid-frame
// drops the old frame silently.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_vector_packet_framer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      tx_word,
  output logic             chunk_last,
  output logic             frame_last,
  output logic             rejected
);
  import mvpf_pkg::*;

  logic q_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic head_valid;
  op_t  head_op;

  // front end: index, checks, classification of each word
  mvpf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_word   (data_word),
    .frame_start (frame_start),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op)
  );

  // decouple the two halves so each can stall on its own
  mvpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // back end: markers, chunk count, output register
  mvpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_word    (tx_word),
    .chunk_last (chunk_last),
    .frame_last (frame_last),
    .rejected   (rejected)
  );

endmodule

`default_nettype wire

/* rtl/mvpf_checker.sv */
// ----------------------------------------------------------------------------
// Motion-vector packet framer port checker
// Watches the top-level ports and flags illegal output sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] tx_word,
  input wire logic        chunk_last,
  input wire logic        frame_last,
  input wire logic        rejected
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_word) && $stable(chunk_last)
      && $stable(frame_last) && $stable(rejected))
    else $error("output word changed while stalled");

  // leave reset empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output valid or input stalled after reset");

  // a rejection is a zero, final word that does not close a chunk
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> tx_word == 32'd0 && frame_last && !chunk_last)
    else $error("malformed rejection word");

  // the final word of a good frame also closes its chunk
  a_last_closes_chunk: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last && !rejected |-> chunk_last)
    else $error("frame end without chunk end");

endmodule

bind motion_vector_packet_framer mvpf_checker u_mvpf_checker (.*);

`default_nettype wire
